[rtl/pcfs_pkg.sv]
// Package for the periodic CAN frame scheduler: frame kinds, identifiers,
// timer periods, register map and the structs passed between the blocks.
// No dependencies.
package pcfs_pkg;

    // Frame kinds, in the order they are checked and sent
    localparam int NUM_FRAMES  = 6;
    localparam int FRM_TORQUE  = 0;
    localparam int FRM_RPM     = 1;
    localparam int FRM_SPEED   = 2;
    localparam int FRM_TEMP    = 3;
    localparam int FRM_FUEL    = 4;
    localparam int FRM_BATTERY = 5;

    // One-hot selects of the frame kinds within a due mask
    localparam logic [NUM_FRAMES-1:0] MASK_TORQUE  = 6'b000001;
    localparam logic [NUM_FRAMES-1:0] MASK_RPM     = 6'b000010;
    localparam logic [NUM_FRAMES-1:0] MASK_SPEED   = 6'b000100;
    localparam logic [NUM_FRAMES-1:0] MASK_TEMP    = 6'b001000;
    localparam logic [NUM_FRAMES-1:0] MASK_FUEL    = 6'b010000;
    localparam logic [NUM_FRAMES-1:0] MASK_BATTERY = 6'b100000;

    // CAN identifiers
    localparam logic [10:0] ID_TORQUE  = 11'h0A8;
    localparam logic [10:0] ID_RPM     = 11'h0AA;
    localparam logic [10:0] ID_SPEED   = 11'h1A6;
    localparam logic [10:0] ID_TEMP    = 11'h1D0;
    localparam logic [10:0] ID_FUEL    = 11'h349;
    localparam logic [10:0] ID_BATTERY = 11'h3B4;

    localparam logic [3:0] LEN_FULL = 4'd8;
    localparam logic [3:0] LEN_FUEL = 4'd5;

    // Send periods in ms and timer values after reset
    localparam logic [31:0] PERIOD [NUM_FRAMES] =
        '{32'd10, 32'd10, 32'd100, 32'd200, 32'd200, 32'd4000};
    localparam logic [31:0] TIMER_RESET [NUM_FRAMES] =
        '{32'd18, 32'd6, 32'd4, 32'd20, 32'd24, 32'd28};

    // Reciprocal multipliers: x/50 = (x*M50)>>36, x/3 = (x*M3)>>33, exact for 32-bit x
    localparam logic [31:0] DIV50_MAGIC = 32'h51EB_851F;
    localparam int          DIV50_SHIFT = 36;
    localparam logic [31:0] DIV3_MAGIC  = 32'hAAAA_AAAB;
    localparam int          DIV3_SHIFT  = 33;

    localparam logic [15:0] SPEED_COUNTER_STEP = 16'd200;
    localparam logic [7:0]  TEMP_OFFSET        = 8'd48;
    localparam logic [7:0]  FUEL_SCALE         = 8'd160;
    localparam logic [6:0]  BATTERY_SCALE      = 7'd68;
    localparam logic [7:0]  BATTERY_HI_OFFSET  = 8'd240;

    localparam int QUEUE_DEPTH = 4;

    // Register map (word index)
    localparam logic [2:0] REG_ENGINE_RPM      = 3'd0;
    localparam logic [2:0] REG_ENGINE_TORQUE   = 3'd1;
    localparam logic [2:0] REG_INJECTOR_VOLUME = 3'd2;
    localparam logic [2:0] REG_BATTERY_VOLTS   = 3'd3;
    localparam logic [2:0] REG_ENGINE_TEMP     = 3'd4;

    localparam logic [13:0]       RST_ENGINE_RPM      = 14'd900;
    localparam logic [10:0]       RST_ENGINE_TORQUE   = 11'd2;
    localparam logic [7:0]        RST_INJECTOR_VOLUME = 8'd7;
    localparam logic [7:0]        RST_BATTERY_VOLTS   = 8'd12;
    localparam logic signed [8:0] RST_ENGINE_TEMP     = 9'sd20;

    // One input tick
    typedef struct packed {
        logic       engine_running;
        logic [8:0] fuel_level;
        logic       brake_active;
        logic       clutch_pressed;
        logic [8:0] speed_kmh;
        logic       ignition_on;
        logic [31:0] now_ms;
    } pcfs_tick_t;

    // Configuration registers
    typedef struct packed {
        logic [13:0]       engine_rpm;
        logic [10:0]       engine_torque;
        logic [7:0]        injector_volume;
        logic [7:0]        battery_volts;
        logic signed [8:0] engine_temp;
    } pcfs_cfg_t;

    // Classified tick handed from front to back
    typedef struct packed {
        logic [NUM_FRAMES-1:0] mask;
        logic                  clutch_pressed;
        logic                  brake_active;
        logic [8:0]            fuel_level;
        logic                  engine_running;
        logic [15:0]           speed_inc;
    } pcfs_job_t;

    // One CAN frame, data[0] is byte 0
    typedef struct packed {
        logic [7:0][7:0] data;
        logic [3:0]      length;
        logic [10:0]     id;
    } pcfs_frame_t;

endpackage

[rtl/pcfs_front.sv]
// Front end of the scheduler: takes ticks, checks the six send timers and
// works out the speed increment in a multiplier pipeline. Uses pcfs_pkg.
module pcfs_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tick_valid,
    output logic                tick_ready,
    input  pcfs_pkg::pcfs_tick_t tick,
    output logic                push,
    output pcfs_pkg::pcfs_job_t push_job,
    input  logic                q_full
);

    logic [31:0] timer_reg [pcfs_pkg::NUM_FRAMES];
    logic [31:0] elapsed   [pcfs_pkg::NUM_FRAMES];
    logic [pcfs_pkg::NUM_FRAMES-1:0] due;

    logic                accept;
    logic                en;

    // stage A: classified tick and speed elapsed time
    logic                valid_a_reg;
    pcfs_pkg::pcfs_job_t job_a_reg;
    logic [31:0]         el_a_reg;
    logic [8:0]          kmh_a_reg;
    // stage B: elapsed / 50
    logic                valid_b_reg;
    pcfs_pkg::pcfs_job_t job_b_reg;
    logic [26:0]         quot_b_reg;
    logic [8:0]          kmh_b_reg;
    // stage C: times speed, wrapped at 32 bits
    logic                valid_c_reg;
    pcfs_pkg::pcfs_job_t job_c_reg;
    logic [31:0]         prod_c_reg;
    // stage D: divided by 3, ready for the queue
    logic                valid_d_reg;
    pcfs_pkg::pcfs_job_t job_d_reg;

    logic [63:0] div50_prod;
    logic [34:0] speed_prod;
    logic [63:0] div3_prod;

    // Whole pipeline advances unless the last stage holds a job the queue cannot take
    assign en         = !(valid_d_reg && (job_d_reg.mask != '0)) || !q_full;
    assign tick_ready = en;
    assign accept     = tick_valid && en;
    assign push       = valid_d_reg && (job_d_reg.mask != '0) && !q_full;
    assign push_job   = job_d_reg;

    // Timer checks, with wrapping differences
    always_comb
    begin
        for (int i = 0; i < pcfs_pkg::NUM_FRAMES; i++)
        begin
            elapsed[i] = tick.now_ms - timer_reg[i];
            due[i]     = tick.ignition_on && (elapsed[i] >= pcfs_pkg::PERIOD[i]);
        end
    end

    // Restart each timer that fires
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pcfs_pkg::NUM_FRAMES; i++)
                timer_reg[i] <= pcfs_pkg::TIMER_RESET[i];
        end
        else if (accept)
        begin
            for (int i = 0; i < pcfs_pkg::NUM_FRAMES; i++)
                if (due[i])
                    timer_reg[i] <= tick.now_ms;
        end
    end

    assign div50_prod = 64'(el_a_reg) * 64'(pcfs_pkg::DIV50_MAGIC);
    assign speed_prod = 35'(quot_b_reg) * 35'(kmh_b_reg);
    assign div3_prod  = 64'(prod_c_reg) * 64'(pcfs_pkg::DIV3_MAGIC);

    // Pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
            valid_d_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_a_reg <= tick_valid;
            valid_b_reg <= valid_a_reg;
            valid_c_reg <= valid_b_reg;
            valid_d_reg <= valid_c_reg;
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            job_a_reg.mask           <= due;
            job_a_reg.clutch_pressed <= tick.clutch_pressed;
            job_a_reg.brake_active   <= tick.brake_active;
            job_a_reg.fuel_level     <= tick.fuel_level;
            job_a_reg.engine_running <= tick.engine_running;
            job_a_reg.speed_inc      <= '0;
            el_a_reg                 <= elapsed[pcfs_pkg::FRM_SPEED];
            kmh_a_reg                <= tick.speed_kmh;

            job_b_reg  <= job_a_reg;
            quot_b_reg <= 27'(div50_prod >> pcfs_pkg::DIV50_SHIFT);
            kmh_b_reg  <= kmh_a_reg;

            job_c_reg  <= job_b_reg;
            prod_c_reg <= speed_prod[31:0];

            job_d_reg.mask           <= job_c_reg.mask;
            job_d_reg.clutch_pressed <= job_c_reg.clutch_pressed;
            job_d_reg.brake_active   <= job_c_reg.brake_active;
            job_d_reg.fuel_level     <= job_c_reg.fuel_level;
            job_d_reg.engine_running <= job_c_reg.engine_running;
            job_d_reg.speed_inc      <= 16'(div3_prod >> pcfs_pkg::DIV3_SHIFT);
        end
    end

endmodule

[rtl/pcfs_queue.sv]
// Short FIFO of classified ticks between front and back end.
// Uses pcfs_pkg for the job struct.
module pcfs_queue
#(
    parameter int DEPTH = pcfs_pkg::QUEUE_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  pcfs_pkg::pcfs_job_t push_job,
    output logic                full,
    input  logic                pop,
    output logic                pop_valid,
    output pcfs_pkg::pcfs_job_t pop_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pcfs_pkg::pcfs_job_t entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_job   = entry_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

[rtl/pcfs_back.sv]
// Back end of the scheduler: walks the due mask of each tick, builds one
// CAN frame per cycle into the output register while out_ready lets it,
// and keeps the rolling counters. Uses pcfs_pkg.
module pcfs_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  pcfs_pkg::pcfs_cfg_t   cfg,
    input  logic                  q_valid,
    input  pcfs_pkg::pcfs_job_t   q_job,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output pcfs_pkg::pcfs_frame_t out_frame,
    output logic                  out_last
);

    logic                job_valid_reg, job_valid_next;
    logic [pcfs_pkg::NUM_FRAMES-1:0] mask_reg, mask_next;
    pcfs_pkg::pcfs_job_t job_reg;

    logic [15:0] speed_accum_reg;
    logic [15:0] speed_counter_reg;
    logic [15:0] injector_total_reg;
    logic [7:0]  temp_count_reg;

    logic                  out_valid_reg, out_valid_next;
    pcfs_pkg::pcfs_frame_t frame_reg, frame_next;
    logic                  last_reg;

    logic [pcfs_pkg::NUM_FRAMES-1:0] sel;
    logic [pcfs_pkg::NUM_FRAMES-1:0] rest;
    logic        last;
    logic        load;
    logic        emit;
    logic [15:0] accum_sum;
    logic [15:0] torque_val;
    logic [15:0] rpm_val;
    logic [16:0] fuel_prod;
    logic [14:0] batt_prod;
    logic [7:0]  temp_byte;

    // Pick the lowest due frame still pending
    assign sel  = mask_reg & (~mask_reg + pcfs_pkg::NUM_FRAMES'(1));
    assign rest = mask_reg & ~sel;
    assign last = (rest == '0);

    assign load  = !out_valid_reg || out_ready;
    assign emit  = job_valid_reg && load;
    assign q_pop = q_valid && (!job_valid_reg || (emit && last));

    assign out_valid = out_valid_reg;
    assign out_frame = frame_reg;
    assign out_last  = last_reg;

    // Job sequencing
    always_comb
    begin
        job_valid_next = job_valid_reg;
        mask_next      = mask_reg;
        if (q_pop)
        begin
            job_valid_next = 1'b1;
            mask_next      = q_job.mask;
        end
        else if (emit)
        begin
            job_valid_next = !last;
            mask_next      = rest;
        end
        out_valid_next = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    // Scaled values
    assign accum_sum  = speed_accum_reg + job_reg.speed_inc;
    assign torque_val = {cfg.engine_torque, 5'b0};
    assign rpm_val    = {cfg.engine_rpm, 2'b0};
    assign fuel_prod  = 17'(job_reg.fuel_level) * 17'(pcfs_pkg::FUEL_SCALE);
    assign batt_prod  = 15'(cfg.battery_volts) * 15'(pcfs_pkg::BATTERY_SCALE);
    assign temp_byte  = cfg.engine_temp[7:0] + pcfs_pkg::TEMP_OFFSET;

    // Frame builder
    always_comb
    begin
        frame_next        = '0;
        frame_next.length = pcfs_pkg::LEN_FULL;
        case (sel)
            pcfs_pkg::MASK_TORQUE:
            begin
                frame_next.id      = pcfs_pkg::ID_TORQUE;
                frame_next.data[0] = 8'h54;
                frame_next.data[1] = torque_val[7:0];
                frame_next.data[2] = torque_val[15:8];
                frame_next.data[3] = torque_val[7:0];
                frame_next.data[4] = torque_val[15:8];
                frame_next.data[5] = job_reg.clutch_pressed ? 8'hF1 : 8'hF0;
                frame_next.data[6] = 8'h03;
                frame_next.data[7] = job_reg.brake_active ? 8'h20 : 8'h02;
            end
            pcfs_pkg::MASK_RPM:
            begin
                frame_next.id      = pcfs_pkg::ID_RPM;
                frame_next.data[0] = 8'hFE;
                frame_next.data[1] = 8'hFE;
                frame_next.data[2] = 8'hFF;
                frame_next.data[3] = 8'h00;
                frame_next.data[4] = rpm_val[7:0];
                frame_next.data[5] = rpm_val[15:8];
                frame_next.data[6] = 8'hFE;
                frame_next.data[7] = 8'h99;
            end
            pcfs_pkg::MASK_SPEED:
            begin
                frame_next.id      = pcfs_pkg::ID_SPEED;
                frame_next.data[0] = accum_sum[7:0];
                frame_next.data[1] = accum_sum[15:8];
                frame_next.data[2] = accum_sum[7:0];
                frame_next.data[3] = accum_sum[15:8];
                frame_next.data[4] = accum_sum[7:0];
                frame_next.data[5] = accum_sum[15:8];
                frame_next.data[6] = speed_counter_reg[7:0];
                frame_next.data[7] = speed_counter_reg[15:8] | 8'hF0;
            end
            pcfs_pkg::MASK_TEMP:
            begin
                frame_next.id      = pcfs_pkg::ID_TEMP;
                frame_next.data[0] = temp_byte;
                frame_next.data[1] = temp_byte;
                frame_next.data[2] = temp_count_reg;
                frame_next.data[3] = 8'hCB;
                frame_next.data[4] = injector_total_reg[7:0];
                frame_next.data[5] = injector_total_reg[15:8];
                frame_next.data[6] = job_reg.clutch_pressed ? 8'hCD : 8'hCC;
                frame_next.data[7] = 8'h90;
            end
            pcfs_pkg::MASK_FUEL:
            begin
                frame_next.id      = pcfs_pkg::ID_FUEL;
                frame_next.length  = pcfs_pkg::LEN_FUEL;
                frame_next.data[0] = fuel_prod[7:0];
                frame_next.data[1] = fuel_prod[15:8];
                frame_next.data[2] = fuel_prod[7:0];
                frame_next.data[3] = fuel_prod[15:8];
            end
            pcfs_pkg::MASK_BATTERY:
            begin
                frame_next.id      = pcfs_pkg::ID_BATTERY;
                frame_next.data[0] = batt_prod[7:0];
                frame_next.data[1] = {1'b0, batt_prod[14:8]} + pcfs_pkg::BATTERY_HI_OFFSET;
                frame_next.data[2] = job_reg.engine_running ? 8'h00 : 8'h09;
                frame_next.data[3] = 8'hFF;
                frame_next.data[4] = 8'hFF;
                frame_next.data[5] = 8'hFF;
                frame_next.data[6] = 8'hFF;
                frame_next.data[7] = 8'hFF;
            end
            default:
            begin
                frame_next = '0;
            end
        endcase
    end

    // Control state and rolling counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg      <= 1'b0;
            mask_reg           <= '0;
            out_valid_reg      <= 1'b0;
            speed_accum_reg    <= '0;
            speed_counter_reg  <= '0;
            injector_total_reg <= '0;
            temp_count_reg     <= '0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
            if (emit && (sel == pcfs_pkg::MASK_SPEED))
            begin
                speed_accum_reg   <= accum_sum;
                speed_counter_reg <= speed_counter_reg + pcfs_pkg::SPEED_COUNTER_STEP;
            end
            if (emit && (sel == pcfs_pkg::MASK_TEMP))
            begin
                injector_total_reg <= injector_total_reg + 16'(cfg.injector_volume);
                temp_count_reg     <= temp_count_reg + 8'd1;
            end
        end
    end

    // Job payload and output register
    always_ff @(posedge clk)
    begin
        if (q_pop)
            job_reg <= q_job;
        if (emit)
        begin
            frame_reg <= frame_next;
            last_reg  <= last;
        end
    end

endmodule

[rtl/periodic_can_frame_scheduler.sv]
// Top level of the periodic CAN frame scheduler: stream ports, APB register
// block, and the front end, queue and back end. Uses pcfs_pkg and pcfs_front,
// pcfs_queue, pcfs_back.

// One tick beat is taken per clock while the queue has room; the front end
// checks the six send timers at acceptance and runs the speed scaling through
// a four-stage multiplier pipeline. The first frame of a tick is offered once
// it has passed stages A to D, the queue and the back end's job and output
// registers. The back end sends one frame per cycle while m_tready is high,
// so a tick with n due frames gives n beats (at most six); that frame builder
// sets the sustained rate. Frames of one tick come out in the order torque,
// rpm, speed, temperature, fuel, battery, the last one with m_tlast set; a
// tick with ignition off or nothing due gives no beat at all. There is no
// clearing pass after reset. Registers are written over APB at byte addresses
// 0, 4, 8, 12 and 16 and should only be changed while the block is idle.
module periodic_can_frame_scheduler
#(
    parameter int QUEUE_DEPTH = pcfs_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    // tick stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata, from bit 0: now_ms[31:0], ignition_on, speed_kmh[8:0],
    // clutch_pressed, brake_active, fuel_level[8:0], engine_running, 2 zero bits
    input  logic [55:0] s_tdata,
    // frame stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata, from bit 0: frame_id[10:0], frame_length[3:0], byte_0 .. byte_7,
    // 1 zero bit
    output logic [79:0] m_tdata,
    output logic        m_tlast,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    pcfs_pkg::pcfs_tick_t  tick;
    pcfs_pkg::pcfs_cfg_t   cfg;
    pcfs_pkg::pcfs_job_t   push_job;
    pcfs_pkg::pcfs_job_t   pop_job;
    pcfs_pkg::pcfs_frame_t frame;
    logic push;
    logic pop;
    logic q_full;
    logic q_valid;
    logic cfg_wr;

    logic [13:0]       engine_rpm_reg;
    logic [10:0]       engine_torque_reg;
    logic [7:0]        injector_volume_reg;
    logic [7:0]        battery_volts_reg;
    logic signed [8:0] engine_temp_reg;

    // Unpack the tick beat
    assign tick.now_ms         = s_tdata[31:0];
    assign tick.ignition_on    = s_tdata[32];
    assign tick.speed_kmh      = s_tdata[41:33];
    assign tick.clutch_pressed = s_tdata[42];
    assign tick.brake_active   = s_tdata[43];
    assign tick.fuel_level     = s_tdata[52:44];
    assign tick.engine_running = s_tdata[53];

    // Register block
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            engine_rpm_reg      <= pcfs_pkg::RST_ENGINE_RPM;
            engine_torque_reg   <= pcfs_pkg::RST_ENGINE_TORQUE;
            injector_volume_reg <= pcfs_pkg::RST_INJECTOR_VOLUME;
            battery_volts_reg   <= pcfs_pkg::RST_BATTERY_VOLTS;
            engine_temp_reg     <= pcfs_pkg::RST_ENGINE_TEMP;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                pcfs_pkg::REG_ENGINE_RPM:      engine_rpm_reg      <= pwdata[13:0];
                pcfs_pkg::REG_ENGINE_TORQUE:   engine_torque_reg   <= pwdata[10:0];
                pcfs_pkg::REG_INJECTOR_VOLUME: injector_volume_reg <= pwdata[7:0];
                pcfs_pkg::REG_BATTERY_VOLTS:   battery_volts_reg   <= pwdata[7:0];
                pcfs_pkg::REG_ENGINE_TEMP:     engine_temp_reg     <= $signed(pwdata[8:0]);
                default:                       ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (paddr[4:2])
            pcfs_pkg::REG_ENGINE_RPM:      prdata = 32'(engine_rpm_reg);
            pcfs_pkg::REG_ENGINE_TORQUE:   prdata = 32'(engine_torque_reg);
            pcfs_pkg::REG_INJECTOR_VOLUME: prdata = 32'(injector_volume_reg);
            pcfs_pkg::REG_BATTERY_VOLTS:   prdata = 32'(battery_volts_reg);
            pcfs_pkg::REG_ENGINE_TEMP:     prdata = 32'(engine_temp_reg);
            default:                       prdata = '0;
        endcase
    end

    assign cfg.engine_rpm      = engine_rpm_reg;
    assign cfg.engine_torque   = engine_torque_reg;
    assign cfg.injector_volume = injector_volume_reg;
    assign cfg.battery_volts   = battery_volts_reg;
    assign cfg.engine_temp     = engine_temp_reg;

    pcfs_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (s_tvalid),
        .tick_ready (s_tready),
        .tick       (tick),
        .push       (push),
        .push_job   (push_job),
        .q_full     (q_full)
    );

    pcfs_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (pop),
        .pop_valid (q_valid),
        .pop_job   (pop_job)
    );

    pcfs_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_job     (pop_job),
        .q_pop     (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_frame (frame),
        .out_last  (m_tlast)
    );

    assign m_tdata = {1'b0, frame.data, frame.length, frame.id};

    // Track the previous identifier within a run of frames
    logic        run_open_reg;
    logic [10:0] prev_id_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_open_reg <= 1'b0;
            prev_id_reg  <= '0;
        end
        else if (m_tvalid && m_tready)
        begin
            run_open_reg <= !m_tlast;
            prev_id_reg  <= frame.id;
        end
    end

    // Only ticks with at least one due frame enter the queue
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (push_job.mask != '0))
        else $error("empty job pushed into queue");

    // Frames of one tick come out in rising identifier order
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && run_open_reg) |-> (frame.id > prev_id_reg))
        else $error("frame order within a tick broken");

    // A five-byte frame is the fuel frame and carries zero in bytes 5 and 7
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (frame.length == pcfs_pkg::LEN_FUEL)) |->
            (frame.id == pcfs_pkg::ID_FUEL && frame.data[7] == 8'h00
             && frame.data[5] == 8'h00))
        else $error("short frame with stray data");

    // The back end never pops an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("pop from empty queue");

endmodule
